// ===== design/udu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package udu_pkg;

   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned STEP_COUNT = WORD_BITS;

   // operand width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // fault status codes
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_ZERO = 2'd1;
   localparam logic [1:0] FAULT_OVER = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   // what one cell hands to the next
   typedef struct packed {
      logic [1:0] fault;
      word_type   rem;       // partial remainder
      word_type   dvd_quo;   // dividend bits still to shift in, quotient bits shifted in below
      word_type   divisor;
   } stage_type;

endpackage

`default_nettype wire

// ===== design/unsigned_divide_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata (low bit up)                          tuser
// req_      in   dividend_high, dividend_low, divisor_value  width_code
// rsp_      out  quotient_out, remainder_out                 fault_status
//
// one item enters per cycle while the chain advances
// path: one operand/fault stage, then a chain of 64 restoring cells, one quotient bit each
// the last cell is the output register; faulted items show zero quotient and remainder
// when a result waits with rsp_tready low the whole chain holds and req_tready drops
// reset empties the chain by clearing its valid bits; the data registers are not reset

module unsigned_divide_unit
   import udu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [191:0] req_tdata,   // dividend_high, dividend_low, divisor_value
   input  wire logic [1:0]   req_tuser,   // width_code
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // quotient_out, remainder_out
   output logic [1:0]        rsp_tuser    // fault_status
);

   logic      advance;
   logic      valid_chain [STEP_COUNT+1];
   stage_type stage_chain [STEP_COUNT+1];

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   udu_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .valid_in      (req_tvalid),
      .width_code    (req_tuser),
      .dividend_high (req_tdata[63:0]),
      .dividend_low  (req_tdata[127:64]),
      .divisor_value (req_tdata[191:128]),
      .valid_out     (valid_chain[0]),
      .stage_out     (stage_chain[0])
   );

   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_cell
      udu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_chain[i]),
         .stage_in  (stage_chain[i]),
         .valid_out (valid_chain[i+1]),
         .stage_out (stage_chain[i+1])
      );
   end

   assign rsp_tvalid = valid_chain[STEP_COUNT];
   assign rsp_tuser  = stage_chain[STEP_COUNT].fault;
   assign rsp_tdata  = (stage_chain[STEP_COUNT].fault == FAULT_NONE)
                     ? {stage_chain[STEP_COUNT].rem, stage_chain[STEP_COUNT].dvd_quo}
                     : '0;

endmodule

`default_nettype wire

// ===== design/udu_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udu_prep
   import udu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       valid_in,
   input  wire logic [1:0] width_code,
   input  wire word_type   dividend_high,
   input  wire word_type   dividend_low,
   input  wire word_type   divisor_value,
   output logic            valid_out,
   output stage_type       stage_out
);

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in;

   always_comb begin
      word_type hi;
      word_type d;
      hi = '0;
      d  = '0;
      stage_in = '0;
      // narrow widths: whole dividend fits one word, so the remainder starts at zero
      unique case (width_code)
         WIDTH_8: begin
            hi = {56'd0, dividend_low[15:8]};
            d  = {56'd0, divisor_value[7:0]};
            stage_in.rem     = '0;
            stage_in.dvd_quo = {48'd0, dividend_low[15:0]};
         end
         WIDTH_16: begin
            hi = {48'd0, dividend_high[15:0]};
            d  = {48'd0, divisor_value[15:0]};
            stage_in.rem     = '0;
            stage_in.dvd_quo = {32'd0, dividend_high[15:0], dividend_low[15:0]};
         end
         WIDTH_32: begin
            hi = {32'd0, dividend_high[31:0]};
            d  = {32'd0, divisor_value[31:0]};
            stage_in.rem     = '0;
            stage_in.dvd_quo = {dividend_high[31:0], dividend_low[31:0]};
         end
         WIDTH_64: begin
            hi = dividend_high;
            d  = divisor_value;
            stage_in.rem     = dividend_high;
            stage_in.dvd_quo = dividend_low;
         end
         default: begin
            hi = '0;
            d  = '0;
         end
      endcase
      stage_in.divisor = d;
      priority if (d == '0) begin
         stage_in.fault = FAULT_ZERO;
      end else if (hi >= d) begin
         stage_in.fault = FAULT_OVER;
      end else begin
         stage_in.fault = FAULT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ===== design/udu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udu_cell
   import udu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      valid_in,
   input  wire stage_type stage_in,
   output logic           valid_out,
   output stage_type      stage_out
);

   logic      valid_ff;
   stage_type stage_ff;
   stage_type step_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      logic                 carry;
      word_type             shifted;
      logic [WORD_BITS:0]   diff;
      logic                 take;
      carry   = stage_in.rem[WORD_BITS-1];
      shifted = {stage_in.rem[WORD_BITS-2:0], stage_in.dvd_quo[WORD_BITS-1]};
      diff    = {carry, shifted} - {1'b0, stage_in.divisor};
      take    = ~diff[WORD_BITS];
      step_in = stage_in;
      step_in.rem     = take ? diff[WORD_BITS-1:0] : shifted;
      step_in.dvd_quo = {stage_in.dvd_quo[WORD_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= step_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ===== design/udu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udu_checker
   import udu_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   // a faulted item carries no quotient or remainder
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != FAULT_NONE) |-> rsp_tdata == '0)
      else $error("fault item with nonzero data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == FAULT_NONE) || (rsp_tuser == FAULT_ZERO)
                     || (rsp_tuser == FAULT_OVER))
      else $error("undefined fault code");

   // the chain never blocks input while the output side drains
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output ready");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result out of reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind unsigned_divide_unit udu_checker u_udu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== sim/unsigned_divide_unit_checker.sv =====
`timescale 1ns / 1ps

module unsigned_divide_unit_checker
   import udu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [191:0]       req_tdata,   // dividend_high, dividend_low, divisor_value
   input  logic [1:0]         req_tuser,   // width_code
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [127:0]       rsp_tdata,   // quotient_out, remainder_out
   input  logic [1:0]         rsp_tuser,   // fault_status
   output int unsigned        fail_count,
   output int unsigned        pending_count,
   output int unsigned        ok_count,
   output int unsigned        zero_count,
   output int unsigned        over_count
);

   typedef struct packed {
      logic [63:0] quotient;
      logic [63:0] remainder;
      logic [1:0]  fault;
   } div_outcome_type;

   div_outcome_type expected_divs[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      ok_count      = 0;
      zero_count    = 0;
      over_count    = 0;
   end

   function automatic div_outcome_type predict_div(logic [1:0] width, logic [63:0] upper,
                                                   logic [63:0] lower, logic [63:0] divisor);
      div_outcome_type outcome;
      logic [63:0]  mask;
      logic [63:0]  dvsr;
      logic [63:0]  hi_half;
      logic [63:0]  lo_half;
      logic [127:0] dividend;
      logic [127:0] quo;
      logic [127:0] rem;
      mask = ~64'd0 >> (WORD_BITS - (8 << width));
      dvsr = divisor & mask;
      if (width == WIDTH_8) begin
         // at byte width the whole dividend sits in the low 16 bits
         hi_half = {56'd0, lower[15:8]};
         lo_half = {56'd0, lower[7:0]};
      end else begin
         hi_half = upper & mask;
         lo_half = lower & mask;
      end
      outcome = '0;
      if (dvsr == 64'd0) begin
         outcome.fault = FAULT_ZERO;
      end else if (hi_half >= dvsr) begin
         outcome.fault = FAULT_OVER;
      end else begin
         dividend = ({64'd0, hi_half} << (8 << width)) | {64'd0, lo_half};
         quo = dividend / {64'd0, dvsr};
         rem = dividend % {64'd0, dvsr};
         outcome.quotient  = quo[63:0] & mask;
         outcome.remainder = rem[63:0] & mask;
         outcome.fault     = FAULT_NONE;
      end
      return outcome;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] wanted, logic [63:0] seen);
      $display("mismatch at %0t: %s wanted %h saw %h", $realtime, what, wanted, seen);
      fail_count++;
   endtask

   always @(posedge clock) begin
      div_outcome_type want;
      if (!reset) begin
         // retire results first; an item's result never leaves in the cycle the item enters
         if (rsp_tvalid && rsp_tready) begin
            if (expected_divs.size() == 0) begin
               report_mismatch("result with no item pending, quotient", 64'd0, rsp_tdata[63:0]);
            end else begin
               want = expected_divs.pop_front();
               if (rsp_tdata[63:0] !== want.quotient)
                  report_mismatch("quotient", want.quotient, rsp_tdata[63:0]);
               if (rsp_tdata[127:64] !== want.remainder)
                  report_mismatch("remainder", want.remainder, rsp_tdata[127:64]);
               if (rsp_tuser !== want.fault)
                  report_mismatch("fault status", 64'(want.fault), 64'(rsp_tuser));
               case (want.fault)
                  FAULT_ZERO: zero_count++;
                  FAULT_OVER: over_count++;
                  default:    ok_count++;
               endcase
            end
         end
         if (req_tvalid && req_tready)
            expected_divs.push_back(predict_div(req_tuser, req_tdata[63:0],
                                                req_tdata[127:64], req_tdata[191:128]));
      end
      pending_count <= expected_divs.size();
   end

endmodule

// ===== sim/unsigned_divide_unit_tb.sv =====
`timescale 1ns / 1ps

module unsigned_divide_unit_tb;
   import udu_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1830;
   localparam int unsigned LONG_STALL   = 320;
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT  = 300000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;   // dividend_high, dividend_low, divisor_value
   logic [1:0]   req_tuser;   // width_code
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // quotient_out, remainder_out
   logic [1:0]   rsp_tuser;   // fault_status

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned ok_count;
   int unsigned zero_count;
   int unsigned over_count;
   int unsigned stall_asks;
   int unsigned cycle_count;
   int unsigned directed_sent;
   int unsigned random_sent;

   unsigned_divide_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   unsigned_divide_unit_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .ok_count      (ok_count),
      .zero_count    (zero_count),
      .over_count    (over_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: changes its ready pattern every so often, long hold-off on request
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned stalls_served;
      mode          = 0;
      mode_left     = 0;
      stalls_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_asks != stalls_served) begin
            stalls_served++;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // writes the upper dividend half into its place, which is lower[15:8] at byte width
   function automatic logic [127:0] place_upper(logic [1:0] width, logic [63:0] upper,
                                                logic [63:0] lower, logic [63:0] value);
      logic [63:0] mask;
      mask = ~64'd0 >> (WORD_BITS - (8 << width));
      if (width == WIDTH_8)
         lower[15:8] = value[7:0];
      else
         upper = (upper & ~mask) | (value & mask);
      return {upper, lower};
   endfunction

   task automatic send_div(logic [1:0] width, logic [63:0] upper, logic [63:0] lower,
                           logic [63:0] divisor);
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, lower, upper};
      req_tuser  <= width;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_for(int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // random divide; mostly in range, with a share of zero divisors and overflows
   task automatic make_div(output logic [1:0] width, output logic [63:0] upper,
                           output logic [63:0] lower, output logic [63:0] divisor);
      logic [63:0]  mask;
      logic [63:0]  dvsr;
      logic [63:0]  high_half;
      logic [127:0] halves;
      int unsigned  pick;
      width   = 2'($urandom_range(0, 3));
      upper   = rand_word();
      lower   = rand_word();
      divisor = rand_word();
      mask    = ~64'd0 >> (WORD_BITS - (8 << width));
      pick    = $urandom_range(0, 99);
      // small divisors push the quotient into its top bits
      if (pick < 20)
         divisor = (divisor & ~mask) | 64'($urandom_range(1, 15));
      else if (pick < 25)
         divisor = divisor | mask;
      dvsr      = divisor & mask;
      high_half = (width == WIDTH_8) ? {56'd0, lower[15:8]} : (upper & mask);
      pick      = $urandom_range(0, 99);
      if (pick < 6) begin
         divisor = divisor & ~mask;
      end else if (pick < 16) begin
         if (high_half < dvsr)
            high_half = dvsr + 64'($urandom_range(0, 3));
         if (high_half > mask || high_half < dvsr)
            high_half = dvsr;
      end else if (dvsr != 64'd0 && high_half >= dvsr) begin
         high_half = high_half % dvsr;
      end
      halves = place_upper(width, upper, lower, high_half);
      upper  = halves[127:64];
      lower  = halves[63:0];
   endtask

   initial begin
      logic [1:0]   width;
      logic [63:0]  upper;
      logic [63:0]  lower;
      logic [63:0]  divisor;
      logic [63:0]  mask;
      logic [127:0] halves;
      int unsigned  burst_left;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= WIDTH_8;
      stall_asks    <= 0;
      directed_sent = 0;
      random_sent   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int w = 0; w < 4; w++) begin
         width = 2'(w);
         mask  = ~64'd0 >> (WORD_BITS - (8 << width));
         // zero divisor with junk above the operand bits
         send_div(width, ~64'd0, ~64'd0, ~mask);
         // divide by one, widest quotient
         halves = place_upper(width, ~mask, ~64'd0, 64'd0);
         send_div(width, halves[127:64], halves[63:0], ~mask | 64'd1);
         // upper half equal to divisor overflows
         send_div(width, ~64'd0, ~64'd0, ~64'd0);
         // upper half one below divisor, largest quotient and remainder
         halves = place_upper(width, 64'd0, ~64'd0, mask - 64'd1);
         send_div(width, halves[127:64], halves[63:0], mask);
         send_div(width, 64'd0, 64'd0, 64'd1);
         directed_sent += 5;
      end
      wait_drained();

      burst_left = 0;
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 500 || i == 1400) begin
            // long receiver hold-off while items keep coming, fills the chain
            stall_asks <= stall_asks + 1;
            burst_left = 200;
         end else if (i == 1000) begin
            wait_drained();
            burst_left = 0;
         end
         if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 7)
               idle_for($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
         end
         make_div(width, upper, lower, divisor);
         send_div(width, upper, lower, divisor);
         burst_left--;
         random_sent++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d divides (%0d directed, %0d random) over all four widths",
               directed_sent + random_sent, directed_sent, random_sent);
      $display("checked results: %0d in range, %0d zero divisor, %0d quotient overflow",
               ok_count, zero_count, over_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
